>>> rtl/mcrs_pkg.sv
// Shared types and constants of the Modbus coil and register server.
// Used by mcrs_store and modbus_coil_register_server_top; depends on nothing.
package mcrs_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_WORDS_DEF   = 64;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 16;
  localparam int CNT_W  = 10;
  localparam int LEN_W  = 8;
  localparam int OP_W   = 3;

  localparam int COIL_BYTES_MAX = 64;
  localparam int FRAME_OVERHEAD = 9;
  localparam int MULTI_REPLY    = 12;

  localparam logic [OP_W-1:0] OP_READ_BITS  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_WORDS = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_BIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_WORD = 3'd3;
  localparam logic [OP_W-1:0] OP_MULTI_BIT  = 3'd4;
  localparam logic [OP_W-1:0] OP_MULTI_WORD = 3'd5;

  typedef struct packed {
    logic              word_we;
    logic              coil_we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic              coil_wdata;
  } store_req_t;

endpackage

>>> rtl/mcrs_store.sv
// Word and coil memories with registered reads and a clearing pass after reset.
// Depends on mcrs_pkg for the access request type.
module mcrs_store #(
  parameter int TABLE_DEPTH = mcrs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcrs_pkg::store_req_t        req,
  output logic                        clearing,
  output logic [mcrs_pkg::DATA_W-1:0] rd_word,
  output logic                        rd_coil
);
  import mcrs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [DATA_W-1:0] word_mem [TABLE_DEPTH];
  logic              coil_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] rd_word_r;
  logic              rd_coil_r;
  logic              clearing_r;
  logic [AW-1:0]     clr_idx_r;
  logic [AW-1:0]     idx;

  assign idx = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == AW'(TABLE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      word_mem[clr_idx_r] <= '0;
      coil_mem[clr_idx_r] <= 1'b0;
    end else begin
      if (req.word_we) begin
        word_mem[idx] <= req.wdata;
      end
      if (req.coil_we) begin
        coil_mem[idx] <= req.coil_wdata;
      end
    end
    rd_word_r <= word_mem[idx];
    rd_coil_r <= coil_mem[idx];
  end

  assign clearing = clearing_r;
  assign rd_word  = rd_word_r;
  assign rd_coil  = rd_coil_r;

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!req.word_we && !req.coil_we))
    else $error("store write requested during the clearing pass");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (clearing_r && clr_idx_r == AW'(TABLE_DEPTH - 1)) |=> !clearing_r)
    else $error("clearing pass did not end at the last entry");

  a_clear_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(clearing_r) && clearing_r) |-> clr_idx_r == $past(clr_idx_r) + 1'b1)
    else $error("clearing index skipped an entry");

endmodule

>>> rtl/modbus_coil_register_server_top.sv
// Top level of the Modbus coil and register server: request sequencer and reply pipeline.
// Depends on mcrs_pkg and instantiates mcrs_store.
//
// After reset the block clears both stores, one entry per cycle, and holds busy until the
// clearing pass ends. A request is taken when start is high and busy is low. Writes and
// error or empty replies leave busy low, so a new word may follow at once. A word read
// holds busy while it reads count words, one memory read per cycle; a coil read holds busy
// while it reads eight coils per returned byte, since the coil memory gives one bit per read.
// Read data passes from the store's read register to the output register. Each result
// shows on out_strobe for a single cycle, and the receiver cannot hold it off.
module modbus_coil_register_server_top #(
  parameter int TABLE_DEPTH = mcrs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_WORDS   = mcrs_pkg::MAX_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mcrs_pkg::OP_W-1:0]   in_op,
  input  logic [mcrs_pkg::ADDR_W-1:0] in_address,
  input  logic [mcrs_pkg::CNT_W-1:0]  in_count,
  input  logic [mcrs_pkg::DATA_W-1:0] in_value,
  input  logic                        in_run_last,
  output logic                        out_strobe,
  output logic [mcrs_pkg::DATA_W-1:0] out_data,
  output logic [mcrs_pkg::LEN_W-1:0]  out_reply_length,
  output logic                        out_is_last,
  output logic                        out_error
);
  import mcrs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RBIT  = 2'd1;
  localparam logic [1:0] ST_RWORD = 2'd2;

  localparam logic [1:0] KIND_CONST = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] KIND_COIL  = 2'd2;

  localparam logic [ADDR_W:0] DEPTH_LIM = (ADDR_W + 1)'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] COIL_MAX = CNT_W'(8 * COIL_BYTES_MAX);

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_kind_r, s1_kind_nxt;
  logic              s1_inr_r, s1_inr_nxt;
  logic [2:0]        s1_pos_r, s1_pos_nxt;
  logic              s1_last_r, s1_last_nxt;
  logic [LEN_W-1:0]  s1_len_r, s1_len_nxt;
  logic              s1_err_r, s1_err_nxt;

  logic [7:0]        acc_r, acc_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;
  logic              out_err_r;

  store_req_t        req;
  logic              clearing;
  logic [DATA_W-1:0] rd_word;
  logic              rd_coil;

  logic              accept;
  logic              in_inr;
  logic              ptr_inr;
  logic [CNT_W-1:0]  coil_cnt;
  logic [CNT_W:0]    coil_bytes;
  logic [LEN_W-1:0]  coil_len;
  logic [LEN_W-1:0]  word_len;
  logic              coil_bit;
  logic [7:0]        coil_byte;

  mcrs_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .clearing(clearing),
    .rd_word (rd_word),
    .rd_coil (rd_coil)
  );

  assign busy   = !rst_n || clearing || (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign in_inr     = {1'b0, in_address} < DEPTH_LIM;
  assign ptr_inr    = ptr_r < DEPTH_LIM;
  assign coil_cnt   = (in_count > COIL_MAX) ? COIL_MAX : in_count;
  assign coil_bytes = ({1'b0, coil_cnt} + (CNT_W + 1)'(7)) >> 3;
  assign coil_len   = LEN_W'(coil_bytes) + LEN_W'(FRAME_OVERHEAD);
  assign word_len   = LEN_W'({in_count, 1'b0}) + LEN_W'(FRAME_OVERHEAD);

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    n_nxt        = n_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    s1_valid_nxt = 1'b0;
    s1_kind_nxt  = KIND_CONST;
    s1_inr_nxt   = 1'b0;
    s1_pos_nxt   = 3'd0;
    s1_last_nxt  = 1'b1;
    s1_len_nxt   = '0;
    s1_err_nxt   = 1'b0;
    req            = '0;
    req.addr       = in_address;
    req.wdata      = in_value;
    req.coil_wdata = (in_op == OP_WRITE_BIT) ? (|in_value) : in_value[0];
    case (state_r)
      ST_IDLE: begin
        ptr_nxt = {1'b0, in_address};
        n_nxt   = '0;
        if (accept) begin
          case (in_op)
            OP_READ_BITS: begin
              cnt_nxt = coil_cnt;
              len_nxt = coil_len;
              if (coil_cnt == '0) begin
                s1_valid_nxt = 1'b1;
                s1_len_nxt   = coil_len;
              end else begin
                state_nxt = ST_RBIT;
              end
            end
            OP_READ_WORDS: begin
              cnt_nxt = in_count;
              len_nxt = word_len;
              if (in_count > CNT_W'(MAX_WORDS)) begin
                s1_valid_nxt = 1'b1;
                s1_err_nxt   = 1'b1;
              end else if (in_count == '0) begin
                s1_valid_nxt = 1'b1;
                s1_len_nxt   = word_len;
              end else begin
                state_nxt = ST_RWORD;
              end
            end
            OP_WRITE_BIT: begin
              req.coil_we  = in_inr;
              s1_valid_nxt = 1'b1;
            end
            OP_WRITE_WORD: begin
              req.word_we  = in_inr;
              s1_valid_nxt = 1'b1;
            end
            OP_MULTI_BIT: begin
              req.coil_we  = in_inr;
              s1_valid_nxt = in_run_last;
              s1_len_nxt   = LEN_W'(MULTI_REPLY);
            end
            OP_MULTI_WORD: begin
              req.word_we  = in_inr;
              s1_valid_nxt = in_run_last;
              s1_len_nxt   = LEN_W'(MULTI_REPLY);
            end
            default: begin
              s1_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_RWORD: begin
        req.addr     = ptr_r[ADDR_W-1:0];
        s1_valid_nxt = 1'b1;
        s1_kind_nxt  = KIND_WORD;
        s1_inr_nxt   = ptr_inr;
        s1_last_nxt  = (n_r + 1'b1) == cnt_r;
        s1_len_nxt   = len_r;
        ptr_nxt      = ptr_r + 1'b1;
        n_nxt        = n_r + 1'b1;
        if (s1_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RBIT: begin
        req.addr     = ptr_r[ADDR_W-1:0];
        s1_valid_nxt = 1'b1;
        s1_kind_nxt  = KIND_COIL;
        s1_inr_nxt   = (n_r < cnt_r) && ptr_inr;
        s1_pos_nxt   = n_r[2:0];
        s1_last_nxt  = (n_r[2:0] == 3'd7) && (({1'b0, n_r} + 1'b1) >= {1'b0, cnt_r});
        s1_len_nxt   = len_r;
        ptr_nxt      = ptr_r + 1'b1;
        n_nxt        = n_r + 1'b1;
        if (s1_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign coil_bit  = s1_inr_r && rd_coil;
  assign coil_byte = acc_r | ({7'b0, coil_bit} << s1_pos_r);

  always_comb begin
    acc_nxt        = acc_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    if (s1_valid_r) begin
      case (s1_kind_r)
        KIND_WORD: begin
          out_strobe_nxt = 1'b1;
          out_data_nxt   = s1_inr_r ? rd_word : '0;
        end
        KIND_COIL: begin
          if (s1_pos_r == 3'd7) begin
            out_strobe_nxt = 1'b1;
            out_data_nxt   = {8'b0, coil_byte};
            acc_nxt        = '0;
          end else begin
            acc_nxt = coil_byte;
          end
        end
        default: begin
          out_strobe_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      s1_valid_r   <= 1'b0;
      acc_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_valid_r   <= s1_valid_nxt;
      acc_r        <= acc_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    s1_kind_r  <= s1_kind_nxt;
    s1_inr_r   <= s1_inr_nxt;
    s1_pos_r   <= s1_pos_nxt;
    s1_last_r  <= s1_last_nxt;
    s1_len_r   <= s1_len_nxt;
    s1_err_r   <= s1_err_nxt;
    out_data_r <= out_data_nxt;
    out_len_r  <= s1_len_r;
    out_last_r <= s1_last_r;
    out_err_r  <= s1_err_r;
  end

  assign out_strobe       = out_strobe_r;
  assign out_data         = out_data_r;
  assign out_reply_length = out_len_r;
  assign out_is_last      = out_last_r;
  assign out_error        = out_err_r;

  a_err_reply_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_error) |-> (out_is_last && out_reply_length == '0 && out_data == '0))
    else $error("error reply is not a single empty result");

  a_partial_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_kind_r == KIND_COIL && s1_pos_r != 3'd7) |=> !out_strobe_r)
    else $error("result issued for an incomplete coil byte");

  a_read_issues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RWORD || state_r == ST_RBIT) |=> s1_valid_r)
    else $error("read state did not issue a memory read");

  a_no_result_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(clearing) && clearing) |-> !out_strobe)
    else $error("result produced during the clearing pass");

endmodule
